// ===== hdl/sit_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types for the segment intersection test pipeline: coordinate,
// difference and product words, orientation codes and stage enables.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int CoordWidth = 32;
    localparam int DiffWidth  = CoordWidth + 1;
    localparam int ProdWidth  = 2 * DiffWidth;

    typedef logic signed [CoordWidth-1:0] coord_t;
    typedef logic signed [DiffWidth-1:0]  diff_t;
    typedef logic signed [ProdWidth-1:0]  prod_t;

    // Orientation of an ordered point triple
    typedef enum logic [1:0] {
        ORI_COLLINEAR = 2'd0,
        ORI_CW        = 2'd1,
        ORI_CCW       = 2'd2
    } ori_t;

    // Load enables of the three compute stages
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } pipe_ctl_t;

endpackage

// ===== hdl/sit_pair_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_pair_if
// Valid/ready channel that carries one pair of segments per transaction.
// ----------------------------------------------------------------------------
interface sit_pair_if
    import sit_pkg::*;
;
    logic   valid;
    logic   ready;
    coord_t a_start_lat;
    coord_t a_start_lon;
    coord_t a_end_lat;
    coord_t a_end_lon;
    coord_t b_start_lat;
    coord_t b_start_lon;
    coord_t b_end_lat;
    coord_t b_end_lon;

    modport source (
        output valid,
        input  ready,
        output a_start_lat, a_start_lon, a_end_lat, a_end_lon,
        output b_start_lat, b_start_lon, b_end_lat, b_end_lon
    );

    modport sink (
        input  valid,
        output ready,
        input  a_start_lat, a_start_lon, a_end_lat, a_end_lon,
        input  b_start_lat, b_start_lon, b_end_lat, b_end_lon
    );
endinterface

// ===== hdl/sit_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_result_if
// Valid/ready channel that carries one intersection verdict per transaction.
// ----------------------------------------------------------------------------
interface sit_result_if;
    logic valid;
    logic ready;
    logic crosses;

    modport source (
        output valid,
        input  ready,
        output crosses
    );

    modport sink (
        input  valid,
        output ready,
        input  crosses
    );
endinterface

// ===== hdl/sit_orient.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_orient
// Three-stage orientation unit: coordinate differences, exact 33x33 products,
// then a signed compare of the two products to give the orientation code.
// ----------------------------------------------------------------------------
module sit_orient
    import sit_pkg::*;
(
    input  logic      clk,
    input  pipe_ctl_t ctl,
    input  coord_t    p_lat,
    input  coord_t    p_lon,
    input  coord_t    q_lat,
    input  coord_t    q_lon,
    input  coord_t    r_lat,
    input  coord_t    r_lon,
    output ori_t      ori
);

    diff_t qp_lat_reg, qp_lon_reg, rq_lat_reg, rq_lon_reg;
    diff_t qp_lat_next, qp_lon_next, rq_lat_next, rq_lon_next;
    prod_t left_reg, right_reg;
    prod_t left_next, right_next;
    ori_t  ori_reg, ori_next;

    // Stage 1: sign-extended differences, exact at 33 bits
    always_comb
    begin
        qp_lat_next = {q_lat[CoordWidth-1], q_lat} - {p_lat[CoordWidth-1], p_lat};
        qp_lon_next = {q_lon[CoordWidth-1], q_lon} - {p_lon[CoordWidth-1], p_lon};
        rq_lat_next = {r_lat[CoordWidth-1], r_lat} - {q_lat[CoordWidth-1], q_lat};
        rq_lon_next = {r_lon[CoordWidth-1], r_lon} - {q_lon[CoordWidth-1], q_lon};
    end

    // Stage 2: full-width cross-product terms
    always_comb
    begin
        left_next  = ProdWidth'(qp_lat_reg) * ProdWidth'(rq_lon_reg);
        right_next = ProdWidth'(qp_lon_reg) * ProdWidth'(rq_lat_reg);
    end

    // Stage 3: sign of left minus right
    always_comb
    begin
        if (left_reg == right_reg)
        begin
            ori_next = ORI_COLLINEAR;
        end
        else if (left_reg > right_reg)
        begin
            ori_next = ORI_CW;
        end
        else
        begin
            ori_next = ORI_CCW;
        end
    end

    // Advance each stage when its load enable is set
    always_ff @(posedge clk)
    begin
        if (ctl.en1)
        begin
            qp_lat_reg <= qp_lat_next;
            qp_lon_reg <= qp_lon_next;
            rq_lat_reg <= rq_lat_next;
            rq_lon_reg <= rq_lon_next;
        end
        if (ctl.en2)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
        if (ctl.en3)
        begin
            ori_reg <= ori_next;
        end
    end

    assign ori = ori_reg;

endmodule

// ===== hdl/sit_box.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_box
// Inclusive bounding-box test of point q against the box spanned by p and r,
// evaluated in stage 1 and delayed to line up with the orientation unit.
// ----------------------------------------------------------------------------
module sit_box
    import sit_pkg::*;
(
    input  logic      clk,
    input  pipe_ctl_t ctl,
    input  coord_t    p_lat,
    input  coord_t    p_lon,
    input  coord_t    q_lat,
    input  coord_t    q_lon,
    input  coord_t    r_lat,
    input  coord_t    r_lon,
    output logic      in_box
);

    logic lat_ok, lon_ok;
    logic box1_reg, box2_reg, box3_reg;
    logic box1_next;

    // Check each axis between the two bounds, in either order
    always_comb
    begin
        lat_ok = ((q_lat >= p_lat) && (q_lat <= r_lat)) ||
                 ((q_lat >= r_lat) && (q_lat <= p_lat));
        lon_ok = ((q_lon >= p_lon) && (q_lon <= r_lon)) ||
                 ((q_lon >= r_lon) && (q_lon <= p_lon));
        box1_next = lat_ok && lon_ok;
    end

    // Carry the flag alongside the orientation stages
    always_ff @(posedge clk)
    begin
        if (ctl.en1)
        begin
            box1_reg <= box1_next;
        end
        if (ctl.en2)
        begin
            box2_reg <= box1_reg;
        end
        if (ctl.en3)
        begin
            box3_reg <= box2_reg;
        end
    end

    assign in_box = box3_reg;

endmodule

// ===== hdl/segment_intersection_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_test
// Reports whether two line segments with 32-bit lat/lon endpoints touch.
// ----------------------------------------------------------------------------
// Usage:
//   pair   (sink)   one transaction carries segment A and segment B.
//   result (source) one transaction carries crosses for each pair, in order.
// Four cross-product orientations are computed exactly (33-bit differences,
// 66-bit products) and combined with inclusive bounding-box tests for the
// collinear cases.
// Throughput: one pair per cycle while result.ready keeps the output moving;
// the pipeline is difference, product, compare, output register, and the
// 33x33 multipliers of the product stage set the clock.
// Reset: rst_n clears all valid bits; no result is shown until a pair enters.
// Stall: when result.ready is low the output holds; stages behind it keep
// filling bubbles, and pair.ready drops only once every stage holds a pair.
// ----------------------------------------------------------------------------
module segment_intersection_test
    import sit_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sit_pair_if.sink     pair,
    sit_result_if.source result
);

    logic      v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic      crosses_reg, crosses_next;
    logic      ld1, ld2, ld3, ld_out;
    pipe_ctl_t ctl;
    ori_t      o1, o2, o3, o4;
    logic      box1, box2, box3, box4;

    // Load a stage when it is empty or the stage ahead is loading
    always_comb
    begin
        ld_out  = !out_valid_reg || result.ready;
        ld3     = !v3_reg || ld_out;
        ld2     = !v2_reg || ld3;
        ld1     = !v1_reg || ld2;
        ctl.en1 = ld1;
        ctl.en2 = ld2;
        ctl.en3 = ld3;
    end

    assign pair.ready = ld1;

    // Orientations of B's endpoints against A, then A's against B
    sit_orient u_ori1 (
        .clk(clk), .ctl(ctl),
        .p_lat(pair.a_start_lat), .p_lon(pair.a_start_lon),
        .q_lat(pair.a_end_lat),   .q_lon(pair.a_end_lon),
        .r_lat(pair.b_start_lat), .r_lon(pair.b_start_lon),
        .ori(o1)
    );
    sit_orient u_ori2 (
        .clk(clk), .ctl(ctl),
        .p_lat(pair.a_start_lat), .p_lon(pair.a_start_lon),
        .q_lat(pair.a_end_lat),   .q_lon(pair.a_end_lon),
        .r_lat(pair.b_end_lat),   .r_lon(pair.b_end_lon),
        .ori(o2)
    );
    sit_orient u_ori3 (
        .clk(clk), .ctl(ctl),
        .p_lat(pair.b_start_lat), .p_lon(pair.b_start_lon),
        .q_lat(pair.b_end_lat),   .q_lon(pair.b_end_lon),
        .r_lat(pair.a_start_lat), .r_lon(pair.a_start_lon),
        .ori(o3)
    );
    sit_orient u_ori4 (
        .clk(clk), .ctl(ctl),
        .p_lat(pair.b_start_lat), .p_lon(pair.b_start_lon),
        .q_lat(pair.b_end_lat),   .q_lon(pair.b_end_lon),
        .r_lat(pair.a_end_lat),   .r_lon(pair.a_end_lon),
        .ori(o4)
    );

    // Endpoint-in-box tests for the collinear cases
    sit_box u_box1 (
        .clk(clk), .ctl(ctl),
        .p_lat(pair.a_start_lat), .p_lon(pair.a_start_lon),
        .q_lat(pair.b_start_lat), .q_lon(pair.b_start_lon),
        .r_lat(pair.a_end_lat),   .r_lon(pair.a_end_lon),
        .in_box(box1)
    );
    sit_box u_box2 (
        .clk(clk), .ctl(ctl),
        .p_lat(pair.a_start_lat), .p_lon(pair.a_start_lon),
        .q_lat(pair.b_end_lat),   .q_lon(pair.b_end_lon),
        .r_lat(pair.a_end_lat),   .r_lon(pair.a_end_lon),
        .in_box(box2)
    );
    sit_box u_box3 (
        .clk(clk), .ctl(ctl),
        .p_lat(pair.b_start_lat), .p_lon(pair.b_start_lon),
        .q_lat(pair.a_start_lat), .q_lon(pair.a_start_lon),
        .r_lat(pair.b_end_lat),   .r_lon(pair.b_end_lon),
        .in_box(box3)
    );
    sit_box u_box4 (
        .clk(clk), .ctl(ctl),
        .p_lat(pair.b_start_lat), .p_lon(pair.b_start_lon),
        .q_lat(pair.a_end_lat),   .q_lon(pair.a_end_lon),
        .r_lat(pair.b_end_lat),   .r_lon(pair.b_end_lon),
        .in_box(box4)
    );

    // Combine orientations and box tests into the verdict
    always_comb
    begin
        crosses_next = ((o1 != o2) && (o3 != o4)) ||
                       ((o1 == ORI_COLLINEAR) && box1) ||
                       ((o2 == ORI_COLLINEAR) && box2) ||
                       ((o3 == ORI_COLLINEAR) && box3) ||
                       ((o4 == ORI_COLLINEAR) && box4);
    end

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= pair.valid;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
            if (ld_out)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk)
    begin
        if (ld_out && v3_reg)
        begin
            crosses_reg <= crosses_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.crosses = crosses_reg;

`ifndef NO_ASSERTIONS
    // An accepted transaction lands in stage 1
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (pair.valid && pair.ready) |=> v1_reg)
        else $error("accepted transaction did not enter stage 1");

    // A blocked compare stage keeps its transaction
    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !ld3) |=> v3_reg)
        else $error("stalled stage 3 lost its transaction");

    // An open output never blocks the input
    a_open_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg || result.ready) |-> pair.ready)
        else $error("input blocked while output can drain");

    // A result only follows a full compare stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg)) |-> $past(v3_reg))
        else $error("result appeared without a transaction in stage 3");
`endif

endmodule
